>>> design/imuq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package imuq_pkg;

  localparam int WINDOW_DEFAULT = 50;
  localparam int NCH = 6;
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 48;

  localparam logic [CFG_AW-1:0] REG_MEAN_LOW     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MEAN_HIGH    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAIN_LOW     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN_HIGH    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_INPUT_ZERO   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_OUTPUT_SCALE = 3'd5;
  localparam logic [CFG_AW-1:0] REG_OUTPUT_ZERO  = 3'd6;

  localparam logic [47:0] GAIN_RESET = 48'h0100_0100_0100;
  localparam logic [15:0] OUTPUT_SCALE_RESET = 16'd4096;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_WINDOW = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_DEQ    = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_READY   = 2'd1;
  localparam logic [1:0] ST_INVALID     = 2'd2;
  localparam logic [1:0] ST_IMPLAUSIBLE = 2'd3;

  localparam logic signed [15:0] ACCEL_LIMIT = 16'sd20480;
  localparam logic signed [15:0] GYRO_LIMIT  = 16'sd4480;
  localparam logic [25:0] SPEED_LIMIT_Q12 = 26'd245760;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
    logic signed [15:0] sample_4;
    logic signed [15:0] sample_5;
    logic signed [7:0]  model_output;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [7:0] quant_0;
    logic signed [7:0] quant_1;
    logic signed [7:0] quant_2;
    logic signed [7:0] quant_3;
    logic signed [7:0] quant_4;
    logic signed [7:0] quant_5;
    logic [13:0]       speed;
    logic              last_row;
  } out_t;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_REJECT,
    CMD_WINDOW,
    CMD_CLEAR,
    CMD_DEQ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [5:0][15:0]    sample;
    logic signed [8:0]   diff;
  } cmd_t;

  typedef struct packed {
    logic [5:0][15:0]  mean;
    logic [5:0][15:0]  gain;
    logic signed [7:0] input_zero;
    logic [15:0]       output_scale;
  } cfg_t;

endpackage
`default_nettype wire

>>> design/imuq_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module imuq_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       rd,
  output      logic [WIDTH-1:0]           rdata,
  output      logic                       full,
  output      logic                       empty,
  output      logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic do_wr;
  logic do_rd;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end
endmodule
`default_nettype wire

>>> design/imuq_front.sv
`timescale 1ns / 1ps
`default_nettype none
module imuq_front (
  input  wire imuq_pkg::in_t       item,
  input  wire logic                push,
  output      logic                full,
  input  wire logic signed [7:0]   output_zero,
  output      logic                cmd_write,
  output      imuq_pkg::cmd_t      cmd,
  input  wire logic                cmd_full
);
  logic [5:0][15:0] s;
  logic bad;

  assign s = {item.sample_5, item.sample_4, item.sample_3,
              item.sample_2, item.sample_1, item.sample_0};

  always_comb begin
    bad = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if ($signed(s[c]) > imuq_pkg::ACCEL_LIMIT || $signed(s[c]) < -imuq_pkg::ACCEL_LIMIT) begin
        bad = 1'b1;
      end
    end
    for (int c = 3; c < 6; c++) begin
      if ($signed(s[c]) > imuq_pkg::GYRO_LIMIT || $signed(s[c]) < -imuq_pkg::GYRO_LIMIT) begin
        bad = 1'b1;
      end
    end
  end

  always_comb begin
    cmd.sample = s;
    cmd.diff   = $signed({item.model_output[7], item.model_output})
               - $signed({output_zero[7], output_zero});
    unique case (item.mode)
      imuq_pkg::MODE_PUSH:   cmd.kind = bad ? imuq_pkg::CMD_REJECT : imuq_pkg::CMD_PUSH;
      imuq_pkg::MODE_WINDOW: cmd.kind = imuq_pkg::CMD_WINDOW;
      imuq_pkg::MODE_CLEAR:  cmd.kind = imuq_pkg::CMD_CLEAR;
      default:               cmd.kind = imuq_pkg::CMD_DEQ;
    endcase
  end

  assign full      = cmd_full;
  assign cmd_write = push & ~cmd_full;
endmodule
`default_nettype wire

>>> design/imuq_back.sv
`timescale 1ns / 1ps
`default_nettype none
module imuq_back #(
  parameter int WINDOW = imuq_pkg::WINDOW_DEFAULT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire imuq_pkg::cfg_t                          cfg,
  input  wire logic                                    cmd_valid,
  input  wire imuq_pkg::cmd_t                          cmd,
  output      logic                                    cmd_pop,
  input  wire logic [$clog2(imuq_pkg::OUT_DEPTH+1)-1:0] out_count,
  output      logic                                    res_valid,
  output      imuq_pkg::out_t                          res
);
  localparam int SW  = $clog2(WINDOW);
  localparam int FW  = $clog2(WINDOW+1);
  localparam int OCW = $clog2(imuq_pkg::OUT_DEPTH+1) + 1;

  typedef enum logic [1:0] {RK_PLAIN, RK_ROW, RK_DEQ} res_kind_t;

  logic [95:0] ring [WINDOW];

  logic          run;
  logic [SW-1:0] row;
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] write_slot;
  logic [FW-1:0] fill;

  logic credit_ok;
  logic row_issue;
  logic win_start;
  logic row_last;
  logic        iss_valid;
  res_kind_t   iss_kind;
  logic [1:0]  iss_status;
  logic        iss_last;

  logic              s1_valid;
  res_kind_t         s1_kind;
  logic [1:0]        s1_status;
  logic              s1_last;
  logic signed [8:0] s1_diff;
  logic [5:0][15:0]  rdata;

  logic                    s2_valid;
  res_kind_t               s2_kind;
  logic [1:0]              s2_status;
  logic                    s2_last;
  logic signed [5:0][33:0] s2_prod;
  logic signed [25:0]      s2_raw;

  logic signed [5:0][33:0] prod_next;
  logic signed [25:0]      raw_next;
  logic [5:0][7:0]         q;
  logic [25:0]             raw_mag;
  logic [25:0]             raw_rnd;

  function automatic logic [7:0] quant(input logic signed [33:0] p,
                                       input logic signed [7:0] zero);
    logic [33:0]        mag;
    logic [18:0]        r;
    logic signed [20:0] sum;
    mag = p[33] ? 34'(-p) : p;
    r   = 19'((mag + 34'd16384) >> 15);
    sum = p[33] ? -$signed({2'b00, r}) : $signed({2'b00, r});
    sum = sum + $signed({{13{zero[7]}}, zero});
    if (sum > 21'sd127) begin
      return 8'sd127;
    end else if (sum < -21'sd128) begin
      return 8'h80;
    end
    return sum[7:0];
  endfunction

  assign credit_ok = ((OCW'(out_count) + OCW'(s1_valid) + OCW'(s2_valid))
                      < OCW'(imuq_pkg::OUT_DEPTH));
  assign cmd_pop   = cmd_valid & ~run & credit_ok;
  assign win_start = cmd_pop & (cmd.kind == imuq_pkg::CMD_WINDOW) & (fill == FW'(WINDOW));
  assign row_issue = run & credit_ok;
  assign row_last  = (row == SW'(WINDOW-1));

  always_comb begin
    iss_valid  = 1'b0;
    iss_kind   = RK_PLAIN;
    iss_status = imuq_pkg::ST_OK;
    iss_last   = 1'b1;
    if (row_issue) begin
      iss_valid = 1'b1;
      iss_kind  = RK_ROW;
      iss_last  = row_last;
    end else if (cmd_pop && !win_start) begin
      iss_valid = 1'b1;
      unique case (cmd.kind)
        imuq_pkg::CMD_REJECT: iss_status = imuq_pkg::ST_INVALID;
        imuq_pkg::CMD_WINDOW: iss_status = imuq_pkg::ST_NOT_READY;
        imuq_pkg::CMD_DEQ:    iss_kind   = RK_DEQ;
        default:              iss_status = imuq_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= 1'b0;
      row        <= '0;
      rd_slot    <= '0;
      write_slot <= '0;
      fill       <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      s1_valid <= iss_valid;
      s2_valid <= s1_valid;
      if (row_issue) begin
        rd_slot <= (rd_slot == SW'(WINDOW-1)) ? '0 : rd_slot + 1'b1;
        if (row_last) begin
          run <= 1'b0;
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else if (win_start) begin
        run     <= 1'b1;
        row     <= '0;
        rd_slot <= write_slot;
      end
      if (cmd_pop && cmd.kind == imuq_pkg::CMD_PUSH) begin
        write_slot <= (write_slot == SW'(WINDOW-1)) ? '0 : write_slot + 1'b1;
        if (fill != FW'(WINDOW)) begin
          fill <= fill + 1'b1;
        end
      end else if (cmd_pop && cmd.kind == imuq_pkg::CMD_CLEAR) begin
        write_slot <= '0;
        fill       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == imuq_pkg::CMD_PUSH) begin
      ring[write_slot] <= cmd.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (row_issue) begin
      rdata <= ring[rd_slot];
    end
  end

  always_comb begin
    logic signed [16:0] d;
    logic signed [16:0] g;
    for (int c = 0; c < imuq_pkg::NCH; c++) begin
      d = $signed({rdata[c][15], rdata[c]}) - $signed({cfg.mean[c][15], cfg.mean[c]});
      g = $signed({1'b0, cfg.gain[c]});
      prod_next[c] = d * g;
    end
    raw_next = s1_diff * $signed({1'b0, cfg.output_scale});
  end

  always_ff @(posedge clk) begin
    s1_kind   <= iss_kind;
    s1_status <= iss_status;
    s1_last   <= iss_last;
    s1_diff   <= cmd.diff;
    s2_kind   <= s1_kind;
    s2_status <= s1_status;
    s2_last   <= s1_last;
    s2_prod   <= prod_next;
    s2_raw    <= raw_next;
  end

  always_comb begin
    for (int c = 0; c < imuq_pkg::NCH; c++) begin
      q[c] = (s2_kind == RK_ROW) ? quant(s2_prod[c], cfg.input_zero) : 8'd0;
    end
    raw_mag = s2_raw[25] ? 26'(-s2_raw) : s2_raw;
    raw_rnd = s2_raw + 26'sd8;
    res.status   = s2_status;
    res.quant_0  = q[0];
    res.quant_1  = q[1];
    res.quant_2  = q[2];
    res.quant_3  = q[3];
    res.quant_4  = q[4];
    res.quant_5  = q[5];
    res.speed    = '0;
    res.last_row = s2_last;
    if (s2_kind == RK_DEQ) begin
      if (raw_mag > imuq_pkg::SPEED_LIMIT_Q12) begin
        res.status = imuq_pkg::ST_IMPLAUSIBLE;
      end else if (!s2_raw[25] && s2_raw != '0) begin
        res.speed = raw_rnd[17:4];
      end
    end
  end

  assign res_valid = s2_valid;
endmodule
`default_nettype wire

>>> design/imu_window_int8_quantizer_top.sv
// IMU window int8 quantizer.
// Input channel: item is transferred on a clock edge with push high and full
// low. Results: while empty is low, result holds the oldest result; it is
// transferred on a clock edge with pop high. Config: cfg_write with cfg_addr
// and cfg_data writes one register; write only while idle. Push, clear,
// dequantize and a not-ready window request each give one result and
// sustain one item per cycle while the result queue has room and no window
// is running. A full window request gives WINDOW rows from the sample memory
// read port, one per cycle while the result queue has room, after the window
// start is registered. A result passes the command queue, the issue register
// and the multiply register; rounding and saturation feed the result queue.
// The first row of a window also waits until the window start is registered.
// Reset empties both queues, clears the ring fill state and loads the
// register defaults (unit gains, output scale 1.0). When the receiver stops
// popping, the result queue fills, the back end holds, then the command queue
// fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module imu_window_int8_quantizer_top #(
  parameter int WINDOW = imuq_pkg::WINDOW_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output      logic                          full,
  input  wire imuq_pkg::in_t                 item,
  output      logic                          empty,
  input  wire logic                          pop,
  output      imuq_pkg::out_t                result,
  input  wire logic                          cfg_write,
  input  wire logic [imuq_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [imuq_pkg::CFG_DW-1:0]   cfg_data
);
  imuq_pkg::cfg_t    cfg;
  logic signed [7:0] output_zero;

  logic            cmd_write;
  imuq_pkg::cmd_t  cmd_in;
  logic            cmd_full;
  logic            cmd_empty;
  logic            cmd_pop;
  imuq_pkg::cmd_t  cmd_out;
  logic            res_valid;
  imuq_pkg::out_t  res;
  logic [$clog2(imuq_pkg::OUT_DEPTH+1)-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean         <= '0;
      cfg.gain         <= {imuq_pkg::GAIN_RESET, imuq_pkg::GAIN_RESET};
      cfg.input_zero   <= '0;
      cfg.output_scale <= imuq_pkg::OUTPUT_SCALE_RESET;
      output_zero      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        imuq_pkg::REG_MEAN_LOW:     cfg.mean[2:0]    <= cfg_data;
        imuq_pkg::REG_MEAN_HIGH:    cfg.mean[5:3]    <= cfg_data;
        imuq_pkg::REG_GAIN_LOW:     cfg.gain[2:0]    <= cfg_data;
        imuq_pkg::REG_GAIN_HIGH:    cfg.gain[5:3]    <= cfg_data;
        imuq_pkg::REG_INPUT_ZERO:   cfg.input_zero   <= cfg_data[7:0];
        imuq_pkg::REG_OUTPUT_SCALE: cfg.output_scale <= cfg_data[15:0];
        imuq_pkg::REG_OUTPUT_ZERO:  output_zero      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  imuq_front u_front (
    .item        (item),
    .push        (push),
    .full        (full),
    .output_zero (output_zero),
    .cmd_write   (cmd_write),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  imuq_fifo #(
    .DEPTH (imuq_pkg::CMD_DEPTH),
    .WIDTH ($bits(imuq_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_write),
    .wdata (cmd_in),
    .rd    (cmd_pop),
    .rdata (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty),
    .count ()
  );

  imuq_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (res)
  );

  imuq_fifo #(
    .DEPTH (imuq_pkg::OUT_DEPTH),
    .WIDTH ($bits(imuq_pkg::out_t))
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_valid),
    .wdata (res),
    .rd    (pop),
    .rdata (result),
    .full  (),
    .empty (empty),
    .count (out_count)
  );
endmodule
`default_nettype wire

>>> design/imuq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module imuq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        push,
  input wire logic                        full,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire imuq_pkg::out_t              result
);
  logic quant_zero;

  assign quant_zero = (result.quant_0 == '0) && (result.quant_1 == '0) &&
                      (result.quant_2 == '0) && (result.quant_3 == '0) &&
                      (result.quant_4 == '0) && (result.quant_5 == '0);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_error_plain: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status != imuq_pkg::ST_OK |->
      result.last_row && quant_zero && result.speed == '0)
    else $error("error result carries data");

  a_speed_alone: assert property (@(posedge clk) disable iff (rst)
    !empty && result.speed != '0 |-> result.last_row && quant_zero)
    else $error("speed result carries row data");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.speed <= 14'd15360)
    else $error("speed out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");
endmodule

bind imu_window_int8_quantizer_top imuq_checker u_imuq_checker (.*);
`default_nettype wire
